/* src/bmd_pkg.sv */
// Shared types and constants of the block-mean downsampler.
package bmd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_WIDTH     = 2'd0,
    CFG_IN_HEIGHT    = 2'd1,
    CFG_BLOCK_FACTOR = 2'd2
  } cfg_idx_e;

  localparam int IN_WIDTH_W  = 11;
  localparam int IN_HEIGHT_W = 13;
  localparam int FACTOR_W    = 5;
  localparam int OUT_X_W     = 10;
  localparam int OUT_Y_W     = 12;

  localparam int HEIGHT_LIMIT = 4096;

  localparam logic [IN_WIDTH_W-1:0]  IN_WIDTH_RST  = 11'd1024;
  localparam logic [IN_HEIGHT_W-1:0] IN_HEIGHT_RST = 13'd1024;
  localparam logic [FACTOR_W-1:0]    FACTOR_RST    = 5'd2;

  typedef struct packed {
    logic [OUT_X_W-1:0] out_x;
    logic [OUT_Y_W-1:0] out_y;
    logic               frame_last;
  } meta_t;

endpackage

/* src/block_mean_downsampler_core.sv */
// Top level of the block-mean downsampler: raster tracking, column RAM and result path.
//
// Samples arrive in raster order, x fastest, and one is taken every clock while the
// result side keeps up. Each sample does a read-modify-write of the column-sum RAM
// entry of its block column: the read is issued on the transfer, the add and write
// happen from the accumulate-stage registers, and the last write is forwarded so
// consecutive samples of one block row sustain one per cycle. A block's mean leaves,
// after its bottom-right sample, through a pipelined reciprocal multiply with one
// correction step. The RAM needs no clearing pass: the first sample of every block
// overwrites its entry. A register write restarts the frame at the top-left.
module block_mean_downsampler_core #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_FACTOR  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bmd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bmd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       mean_o,
  output logic [bmd_pkg::OUT_X_W-1:0]         out_x_o,
  output logic [bmd_pkg::OUT_Y_W-1:0]         out_y_o,
  output logic                                frame_last_o
);

  localparam int SUMW = SAMPLE_BITS + 2 * $clog2(MAX_FACTOR);
  localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int FCW  = $clog2(MAX_FACTOR + 1);
  localparam int OW   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int XC   = $clog2(MAX_WIDTH + 2 * MAX_FACTOR + 1);
  localparam int YW   = bmd_pkg::OUT_Y_W;
  localparam int HW   = bmd_pkg::IN_HEIGHT_W;
  localparam int YC   = $clog2(bmd_pkg::HEIGHT_LIMIT + 2 * MAX_FACTOR + 1);

  // configuration registers
  logic [bmd_pkg::IN_WIDTH_W-1:0]  in_width_q;
  logic [bmd_pkg::IN_HEIGHT_W-1:0] in_height_q;
  logic [bmd_pkg::FACTOR_W-1:0]    factor_q;
  logic                            restart;

  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      case (bmd_pkg::cfg_idx_e'(cfg_idx_i))
        bmd_pkg::CFG_IN_WIDTH,
        bmd_pkg::CFG_IN_HEIGHT,
        bmd_pkg::CFG_BLOCK_FACTOR: restart = 1'b1;
        default:                   restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= bmd_pkg::IN_WIDTH_RST;
      in_height_q <= bmd_pkg::IN_HEIGHT_RST;
      factor_q    <= bmd_pkg::FACTOR_RST;
    end else if (cfg_we_i) begin
      case (bmd_pkg::cfg_idx_e'(cfg_idx_i))
        bmd_pkg::CFG_IN_WIDTH:     in_width_q  <= cfg_data_i[bmd_pkg::IN_WIDTH_W-1:0];
        bmd_pkg::CFG_IN_HEIGHT:    in_height_q <= cfg_data_i[bmd_pkg::IN_HEIGHT_W-1:0];
        bmd_pkg::CFG_BLOCK_FACTOR: factor_q    <= cfg_data_i[bmd_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [FCW-1:0] f_eff;

  assign w_eff = (in_width_q == '0) ? WW'(1) :
                 (32'(in_width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(in_width_q);
  assign h_eff = (in_height_q == '0) ? HW'(1) :
                 (32'(in_height_q) > bmd_pkg::HEIGHT_LIMIT) ? HW'(bmd_pkg::HEIGHT_LIMIT) :
                 in_height_q;
  assign f_eff = (factor_q == '0) ? FCW'(1) :
                 (32'(factor_q) > MAX_FACTOR) ? FCW'(MAX_FACTOR) : FCW'(factor_q);

  // raster position, block start and block index
  logic [XW-1:0] px_q, xs_q, bx_q;
  logic [YW-1:0] py_q, ys_q, by_q;
  logic [OW-1:0] ox_q, oy_q;

  logic in_x, in_y, last_x, last_y, in_block, ox_end, oy_end, x_wrap, y_wrap;
  logic emit, first;

  assign in_x   = (XC'(xs_q) + XC'(f_eff)) <= XC'(w_eff);
  assign last_x = (XC'(xs_q) + XC'({f_eff, 1'b0})) > XC'(w_eff);
  assign in_y   = (YC'(ys_q) + YC'(f_eff)) <= YC'(h_eff);
  assign last_y = (YC'(ys_q) + YC'({f_eff, 1'b0})) > YC'(h_eff);
  assign in_block = in_x && in_y;

  assign ox_end = ((FCW+1)'(ox_q) + (FCW+1)'(1)) >= (FCW+1)'(f_eff);
  assign oy_end = ((FCW+1)'(oy_q) + (FCW+1)'(1)) >= (FCW+1)'(f_eff);
  assign x_wrap = ((XC'(px_q) + XC'(1)) >= XC'(w_eff));
  assign y_wrap = ((YC'(py_q) + YC'(1)) >= YC'(h_eff));
  assign emit   = ox_end && oy_end;
  assign first  = (ox_q == '0) && (oy_q == '0);

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; xs_q <= '0; bx_q <= '0; ox_q <= '0;
      py_q <= '0; ys_q <= '0; by_q <= '0; oy_q <= '0;
    end else if (restart) begin
      px_q <= '0; xs_q <= '0; bx_q <= '0; ox_q <= '0;
      py_q <= '0; ys_q <= '0; by_q <= '0; oy_q <= '0;
    end else if (accept) begin
      if (x_wrap) begin
        px_q <= '0; xs_q <= '0; bx_q <= '0; ox_q <= '0;
        if (y_wrap) begin
          py_q <= '0; ys_q <= '0; by_q <= '0; oy_q <= '0;
        end else begin
          py_q <= py_q + YW'(1);
          if (oy_end) begin
            oy_q <= '0;
            ys_q <= ys_q + YW'(f_eff);
            by_q <= by_q + YW'(1);
          end else begin
            oy_q <= oy_q + OW'(1);
          end
        end
      end else begin
        px_q <= px_q + XW'(1);
        if (ox_end) begin
          ox_q <= '0;
          xs_q <= xs_q + XW'(f_eff);
          bx_q <= bx_q + XW'(1);
        end else begin
          ox_q <= ox_q + OW'(1);
        end
      end
    end
  end

  // accumulate stage
  logic                          v1_q, s1_first_q, s1_emit_q;
  logic [XW-1:0]                 s1_x_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  bmd_pkg::meta_t                s1_meta_q, meta_in;
  logic                          div_ready, s1_adv, wr_en, rd_en;

  assign meta_in.out_x      = bmd_pkg::OUT_X_W'(bx_q);
  assign meta_in.out_y      = by_q;
  assign meta_in.frame_last = last_x && last_y;

  assign s1_adv     = !s1_emit_q || div_ready;
  assign in_ready_o = !v1_q || s1_adv;
  assign wr_en      = v1_q && s1_adv;
  assign rd_en      = accept && in_block;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_x_q      <= bx_q;
      s1_first_q  <= first;
      s1_emit_q   <= emit;
      s1_sample_q <= sample_i;
      s1_meta_q   <= meta_in;
    end
  end

  // column-sum RAM, one read and one write port, registered read
  logic signed [SUMW-1:0] mem_q [MAX_WIDTH];
  logic signed [SUMW-1:0] rdata_q, base, acc_sum;

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[bx_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[s1_x_q] <= acc_sum;
  end

  // forward the last write: its read may have been issued at the same edge
  logic                   fwd_v_q;
  logic [XW-1:0]          fwd_x_q;
  logic signed [SUMW-1:0] fwd_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (wr_en) begin
      fwd_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_x_q   <= s1_x_q;
      fwd_sum_q <= acc_sum;
    end
  end

  assign base    = (fwd_v_q && (fwd_x_q == s1_x_q)) ? fwd_sum_q : rdata_q;
  assign acc_sum = s1_first_q ? SUMW'(s1_sample_q) : base + SUMW'(s1_sample_q);

  // rounding divide and output register
  bmd_pkg::meta_t meta_out;

  bmd_round_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_FACTOR  (MAX_FACTOR),
    .SUMW        (SUMW),
    .FCW         (FCW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .factor_i    (f_eff),
    .in_valid_i  (v1_q && s1_emit_q),
    .in_ready_o  (div_ready),
    .sum_i       (acc_sum),
    .meta_i      (s1_meta_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .mean_o      (mean_o),
    .meta_o      (meta_out)
  );

  assign out_x_o      = meta_out.out_x;
  assign out_y_o      = meta_out.out_y;
  assign frame_last_o = meta_out.frame_last;

endmodule

/* src/bmd_round_div.sv */
// Pipelined division of a block sum by factor squared, rounded half away from zero.
module bmd_round_div #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_FACTOR  = 16,
  parameter int SUMW        = SAMPLE_BITS + 2 * $clog2(MAX_FACTOR),
  parameter int FCW         = $clog2(MAX_FACTOR + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [FCW-1:0]                factor_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SUMW-1:0]        sum_i,
  input  bmd_pkg::meta_t                meta_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] mean_o,
  output bmd_pkg::meta_t                meta_o
);

  localparam int DW = 2 * FCW;

  // reciprocal table: floor(2^SUMW / f^2)
  logic [SUMW:0] recip_tab [MAX_FACTOR+1];
  assign recip_tab[0] = '0;
  for (genvar g = 1; g <= MAX_FACTOR; g++) begin : g_recip
    localparam logic [63:0] Recip = (64'd1 << SUMW) / (g * g);
    assign recip_tab[g] = Recip[SUMW:0];
  end

  logic [DW-1:0] d_q;
  logic [SUMW:0] recip_q;

  // user must change factor only while idle (unenforced); these settle before sums
  always_ff @(posedge clk_i) begin
    d_q     <= DW'(factor_i) * DW'(factor_i);
    recip_q <= recip_tab[factor_i];
  end

  logic v_a_q, v_b_q, v_c_q, v_o_q;
  logic rdy_a, rdy_b, rdy_c, rdy_o;

  assign rdy_o      = !v_o_q || out_ready_i;
  assign rdy_c      = !v_c_q || rdy_o;
  assign rdy_b      = !v_b_q || rdy_c;
  assign rdy_a      = !v_a_q || rdy_b;
  assign in_ready_o = rdy_a;

  logic signed [SUMW-1:0] sum_a_q;
  bmd_pkg::meta_t         meta_a_q, meta_b_q, meta_c_q, meta_o_q;
  logic [SUMW-1:0]        n_b_q, n_c_q, q_c_q;
  logic                   neg_b_q, neg_c_q;
  logic signed [SAMPLE_BITS-1:0] mean_q;

  // stage a: magnitude plus half divisor
  logic [SUMW-1:0] mag_a, n_a;
  assign mag_a = sum_a_q[SUMW-1] ? (~sum_a_q + SUMW'(1)) : sum_a_q;
  assign n_a   = mag_a + SUMW'(d_q >> 1);

  // stage b: multiply by reciprocal, estimate may be one low
  logic [2*SUMW:0] prod_b;
  assign prod_b = (2*SUMW+1)'(n_b_q) * (2*SUMW+1)'(recip_q);

  // stage c: correct the estimate, apply sign
  logic [SUMW-1:0] qd_c, r_c, q_fix_c, sq_c;
  assign qd_c    = SUMW'(q_c_q * SUMW'(d_q));
  assign r_c     = n_c_q - qd_c;
  assign q_fix_c = (r_c >= SUMW'(d_q)) ? q_c_q + SUMW'(1) : q_c_q;
  assign sq_c    = neg_c_q ? (~q_fix_c + SUMW'(1)) : q_fix_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_o_q <= 1'b0;
    end else begin
      if (rdy_a) v_a_q <= in_valid_i;
      if (rdy_b) v_b_q <= v_a_q;
      if (rdy_c) v_c_q <= v_b_q;
      if (rdy_o) v_o_q <= v_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      sum_a_q  <= sum_i;
      meta_a_q <= meta_i;
    end
    if (rdy_b && v_a_q) begin
      n_b_q    <= n_a;
      neg_b_q  <= sum_a_q[SUMW-1];
      meta_b_q <= meta_a_q;
    end
    if (rdy_c && v_b_q) begin
      q_c_q    <= prod_b[SUMW +: SUMW];
      n_c_q    <= n_b_q;
      neg_c_q  <= neg_b_q;
      meta_c_q <= meta_b_q;
    end
    if (rdy_o && v_c_q) begin
      mean_q   <= sq_c[SAMPLE_BITS-1:0];
      meta_o_q <= meta_c_q;
    end
  end

  assign out_valid_o = v_o_q;
  assign mean_o      = mean_q;
  assign meta_o      = meta_o_q;

endmodule
